/* sv/jam_pkg.sv */
// ----------------------------------------------------------------------------
// jam_pkg: shared types and constants for the joint angle moving average
// Widths, fixed-point constants, register indexes and the control structs
// that pass between the front end, the queue, the back end and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jam_pkg;

  // Field widths
  localparam int READING_W  = 32;
  localparam int ANGLE_W    = 48;
  localparam int TICKS_W    = 24;
  localparam int Q16_W      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Averaging window
  localparam int WINDOW = 8;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int HELD_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = ANGLE_W + HELD_W;

  // Conversion constants: 2pi in Q28 and pi/180 in Q32
  localparam int KQ_W = 31;
  localparam logic [KQ_W-1:0] TAU_Q28 = 31'd1686629713;
  localparam logic [KQ_W-1:0] DEG_Q32 = 31'd74961321;
  localparam int PROD_W = READING_W + KQ_W;

  // Serial divider sizing
  localparam int DIV_NUM_W = PROD_W;
  localparam int DIV_DEN_W = TICKS_W + 12;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Offset and scaling datapath
  localparam int AO_W     = ANGLE_W + 1;
  localparam int PLO_W    = 2 * Q16_W;
  localparam int PHI_W    = (AO_W - Q16_W) + Q16_W;
  localparam int FULL_W   = AO_W + Q16_W;
  localparam int SAT_IN_W = FULL_W - 16;

  // Short queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO  = 8'd3;

  // Register reset values
  localparam logic [TICKS_W-1:0]      TICKS_RESET = 24'd4096;
  localparam logic signed [Q16_W-1:0] RATIO_RESET = 32'sd65536;

  // Saturation limits
  localparam logic [SAT_IN_W-1:0] HALF48 = SAT_IN_W'(1) << (ANGLE_W - 1);
  localparam logic signed [ANGLE_W-1:0] MAX48 = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] MIN48 = {1'b1, {(ANGLE_W-1){1'b0}}};

  typedef struct packed {
    logic                    in_degrees;
    logic [TICKS_W-1:0]      ticks;
    logic signed [Q16_W-1:0] offset;
    logic signed [Q16_W-1:0] ratio;
  } cfg_t;

  typedef struct packed {
    logic                 neg;
    logic [READING_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] numer;
    logic [DIV_DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMUL,
    S_CONV,
    S_CDIV,
    S_WIN,
    S_AGO,
    S_ADIV,
    S_MAG,
    S_PLO,
    S_PHI,
    S_RND
  } back_state_t;

  // Put the sign back on a magnitude and clamp to 48 bits signed
  function automatic logic signed [ANGLE_W-1:0] sat48(input logic [SAT_IN_W-1:0] m,
                                                      input logic neg);
    logic signed [ANGLE_W-1:0] r;
    if (neg) begin
      if (m >= HALF48) begin
        r = MIN48;
      end else begin
        r = -$signed(m[ANGLE_W-1:0]);
      end
    end else begin
      if (m > SAT_IN_W'(MAX48)) begin
        r = MAX48;
      end else begin
        r = $signed(m[ANGLE_W-1:0]);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/jam_in_if.sv */
// ----------------------------------------------------------------------------
// jam_in_if: reading channel
// Carries one raw sensor reading and its read-ok flag under valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jam_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [jam_pkg::READING_W-1:0]   raw_reading;
  logic                                   read_ok;

  modport source (output valid, output raw_reading, output read_ok, input ready);
  modport sink   (input valid, input raw_reading, input read_ok, output ready);
endinterface

`default_nettype wire

/* sv/jam_out_if.sv */
// ----------------------------------------------------------------------------
// jam_out_if: angle channel
// Carries one filtered joint angle under valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jam_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [jam_pkg::ANGLE_W-1:0]   joint_angle;

  modport source (output valid, output joint_angle, input ready);
  modport sink   (input valid, input joint_angle, output ready);
endinterface

`default_nettype wire

/* sv/jam_cfg_if.sv */
// ----------------------------------------------------------------------------
// jam_cfg_if: configuration write channel
// Carries a register index and write data under valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jam_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [jam_pkg::CFG_IDX_W-1:0]     index;
  logic [jam_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/joint_angle_moving_average.sv */
// ----------------------------------------------------------------------------
// joint_angle_moving_average: joint sensor angle filter
// Converts raw ticks or degrees to Q32.16 radians, averages the last WINDOW
// angles, then applies offset and ratio with 48-bit saturation.
//
//   channel  role    payload
//   sample   sink    raw_reading (s32), read_ok (1)
//   result   source  joint_angle (s48)
//   cfg      sink    index (8), data (32); always ready
//
// In tick mode a good reading passes the 63-step serial divider twice, for
// the tick conversion and for the average; in degree mode only once. A
// failed read is dropped on entry. Reset is synchronous and clears the
// window, its sum and counts, and loads the register defaults. Readings
// queue two deep while the back end works. A finished angle waits in the
// output register and holds the back end only at the next rounding step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module joint_angle_moving_average (
  input  logic   clk,
  input  logic   rst,
  jam_in_if.sink     sample,
  jam_out_if.source  result,
  jam_cfg_if.sink    cfg
);

  jam_pkg::cfg_t        regs;
  jam_pkg::push_t       push;
  jam_pkg::fifo_stat_t  stat;
  jam_pkg::item_t       head;
  logic                 pop;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;

  // Register file; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.in_degrees <= 1'b0;
      regs.ticks      <= jam_pkg::TICKS_RESET;
      regs.offset     <= '0;
      regs.ratio      <= jam_pkg::RATIO_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        jam_pkg::REG_MODE:   regs.in_degrees <= cfg.data[0];
        jam_pkg::REG_TICKS:  regs.ticks      <= cfg.data[jam_pkg::TICKS_W-1:0];
        jam_pkg::REG_OFFSET: regs.offset     <= $signed(cfg.data);
        jam_pkg::REG_RATIO:  regs.ratio      <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  jam_front u_front (
    .sample (sample),
    .full   (stat.full),
    .push   (push)
  );

  jam_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .stat (stat),
    .head (head)
  );

  jam_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (regs),
    .empty  (stat.empty),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire

/* sv/jam_front.sv */
// ----------------------------------------------------------------------------
// jam_front: reading intake
// Accepts readings, drops failed reads and splits good ones into sign and
// magnitude before queueing them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jam_front (
  jam_in_if.sink          sample,
  input  logic            full,
  output jam_pkg::push_t  push
);

  logic neg;

  // Take a transaction whenever the queue has room
  assign sample.ready = !full;
  assign neg          = sample.raw_reading[jam_pkg::READING_W-1];

  // Queue good reads only, as sign and magnitude
  always_comb begin
    push.valid    = sample.valid && !full && sample.read_ok;
    push.item.neg = neg;
    push.item.mag = neg ? $unsigned(-sample.raw_reading) : $unsigned(sample.raw_reading);
  end

endmodule

`default_nettype wire

/* sv/jam_fifo.sv */
// ----------------------------------------------------------------------------
// jam_fifo: short item queue
// Decouples the intake from the arithmetic back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jam_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  jam_pkg::push_t        push,
  input  logic                  pop,
  output jam_pkg::fifo_stat_t   stat,
  output jam_pkg::item_t        head
);

  jam_pkg::item_t                entries [jam_pkg::QDEPTH];
  logic [jam_pkg::QPTR_W-1:0]    wr_ptr;
  logic [jam_pkg::QPTR_W-1:0]    rd_ptr;
  logic [jam_pkg::QCNT_W-1:0]    count;

  assign stat.full  = (count == jam_pkg::QCNT_W'(jam_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign head       = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == jam_pkg::QPTR_W'(jam_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == jam_pkg::QPTR_W'(jam_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !stat.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty) else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* sv/jam_div.sv */
// ----------------------------------------------------------------------------
// jam_div: serial unsigned divider
// Restoring division, one quotient bit per cycle, shared by the tick
// conversion and the window average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jam_div (
  input  logic                clk,
  input  logic                rst,
  input  jam_pkg::div_req_t   req,
  output jam_pkg::div_rsp_t   rsp
);

  logic [jam_pkg::DIV_NUM_W-1:0]  n;
  logic [jam_pkg::DIV_DEN_W-1:0]  den;
  logic [jam_pkg::DIV_DEN_W-1:0]  rem;
  logic [jam_pkg::DIV_CNT_W-1:0]  cnt;
  logic                           busy;
  logic                           done;
  logic [jam_pkg::DIV_DEN_W:0]    rs;
  logic [jam_pkg::DIV_DEN_W:0]    diff;
  logic                           ge;

  // Trial subtract of the shifted remainder
  always_comb begin
    rs   = {rem, n[jam_pkg::DIV_NUM_W-1]};
    ge   = (rs >= {1'b0, den});
    diff = rs - {1'b0, den};
  end

  // Load on start, then shift one quotient bit in per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == jam_pkg::DIV_CNT_W'(1));
      if (req.start) begin
        n    <= req.numer;
        den  <= req.denom;
        rem  <= '0;
        cnt  <= jam_pkg::DIV_CNT_W'(jam_pkg::DIV_NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[jam_pkg::DIV_DEN_W-1:0] : rs[jam_pkg::DIV_DEN_W-1:0];
        n   <= {n[jam_pkg::DIV_NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == jam_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = n;

endmodule

`default_nettype wire

/* sv/jam_back.sv */
// ----------------------------------------------------------------------------
// jam_back: conversion, averaging and scaling sequencer
// Converts a queued reading to radians, updates the window, averages,
// applies offset and ratio, and holds the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jam_back (
  input  logic                 clk,
  input  logic                 rst,
  input  jam_pkg::cfg_t        cfg,
  input  logic                 empty,
  input  jam_pkg::item_t       head,
  output logic                 pop,
  jam_out_if.source            result
);

  jam_pkg::back_state_t  state;
  jam_pkg::back_state_t  state_next;
  jam_pkg::div_req_t     div_req;
  jam_pkg::div_rsp_t     div_rsp;

  // Item being worked on
  logic                                  cur_neg;
  logic [jam_pkg::READING_W-1:0]         cur_mag;
  logic [jam_pkg::PROD_W-1:0]            prod;
  logic signed [jam_pkg::ANGLE_W-1:0]    angle;

  // Window state
  logic signed [jam_pkg::ANGLE_W-1:0]    window [jam_pkg::WINDOW];
  logic signed [jam_pkg::SUM_W-1:0]      sum;
  logic [jam_pkg::HELD_W-1:0]            held;
  logic [jam_pkg::SLOT_W-1:0]            slot;

  // Offset and scaling
  logic signed [jam_pkg::AO_W-1:0]       avg_off;
  logic [jam_pkg::AO_W-1:0]              ua;
  logic [jam_pkg::Q16_W-1:0]             ur;
  logic                                  sneg;
  logic [jam_pkg::PLO_W-1:0]             plo;
  logic [jam_pkg::PHI_W-1:0]             phi;

  // Output register
  logic                                  out_valid;
  logic signed [jam_pkg::ANGLE_W-1:0]    out_angle;

  // Combinational helpers
  logic [jam_pkg::KQ_W-1:0]              conv_k;
  logic [jam_pkg::TICKS_W-1:0]           res;
  logic [jam_pkg::PROD_W:0]              deg_round;
  logic [jam_pkg::SUM_W-1:0]             sum_mag;
  logic signed [jam_pkg::AO_W-1:0]       avg_s;
  logic [jam_pkg::FULL_W-1:0]            full_prod;
  logic                                  can_load;

  jam_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Arithmetic feeding the state updates
  always_comb begin
    conv_k    = cfg.in_degrees ? jam_pkg::DEG_Q32 : jam_pkg::TAU_Q28;
    res       = (cfg.ticks == '0) ? jam_pkg::TICKS_W'(1) : cfg.ticks;
    deg_round = (jam_pkg::PROD_W + 1)'(prod) + (jam_pkg::PROD_W + 1)'(16'h8000);
    sum_mag   = sum[jam_pkg::SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);
    avg_s     = sum[jam_pkg::SUM_W-1] ? -$signed(div_rsp.quot[jam_pkg::AO_W-1:0])
                                      : $signed(div_rsp.quot[jam_pkg::AO_W-1:0]);
    full_prod = {phi, {jam_pkg::Q16_W{1'b0}}} + jam_pkg::FULL_W'(plo)
              + jam_pkg::FULL_W'(16'h8000);
    can_load  = !out_valid || result.ready;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jam_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, queue pop and divider requests
  always_comb begin
    state_next    = state;
    pop           = 1'b0;
    div_req.start = 1'b0;
    div_req.numer = '0;
    div_req.denom = '0;
    case (state)
      jam_pkg::S_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = jam_pkg::S_CMUL;
        end
      end
      jam_pkg::S_CMUL: state_next = jam_pkg::S_CONV;
      jam_pkg::S_CONV: begin
        if (cfg.in_degrees) begin
          state_next = jam_pkg::S_WIN;
        end else begin
          div_req.start = 1'b1;
          div_req.numer = prod + jam_pkg::DIV_NUM_W'({res, 11'b0});
          div_req.denom = {res, 12'b0};
          state_next    = jam_pkg::S_CDIV;
        end
      end
      jam_pkg::S_CDIV: begin
        if (div_rsp.done) begin
          state_next = jam_pkg::S_WIN;
        end
      end
      jam_pkg::S_WIN: state_next = jam_pkg::S_AGO;
      jam_pkg::S_AGO: begin
        div_req.start = 1'b1;
        div_req.numer = jam_pkg::DIV_NUM_W'(sum_mag) + jam_pkg::DIV_NUM_W'(held >> 1);
        div_req.denom = jam_pkg::DIV_DEN_W'(held);
        state_next    = jam_pkg::S_ADIV;
      end
      jam_pkg::S_ADIV: begin
        if (div_rsp.done) begin
          state_next = jam_pkg::S_MAG;
        end
      end
      jam_pkg::S_MAG: state_next = jam_pkg::S_PLO;
      jam_pkg::S_PLO: state_next = jam_pkg::S_PHI;
      jam_pkg::S_PHI: state_next = jam_pkg::S_RND;
      jam_pkg::S_RND: begin
        if (can_load) begin
          state_next = jam_pkg::S_IDLE;
        end
      end
      default: state_next = jam_pkg::S_IDLE;
    endcase
  end

  // Datapath and window updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < jam_pkg::WINDOW; i++) begin
        window[i] <= '0;
      end
      sum       <= '0;
      held      <= '0;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a new result from the rounding step, else drop the held one once taken
      if ((state == jam_pkg::S_RND) && can_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        jam_pkg::S_IDLE: begin
          if (!empty) begin
            cur_neg <= head.neg;
            cur_mag <= head.mag;
          end
        end
        jam_pkg::S_CMUL: prod <= cur_mag * conv_k;
        jam_pkg::S_CONV: begin
          if (cfg.in_degrees) begin
            angle <= jam_pkg::sat48(jam_pkg::SAT_IN_W'(deg_round[jam_pkg::PROD_W:16]),
                                    cur_neg);
          end
        end
        jam_pkg::S_CDIV: begin
          if (div_rsp.done) begin
            angle <= jam_pkg::sat48(jam_pkg::SAT_IN_W'(div_rsp.quot), cur_neg);
          end
        end
        jam_pkg::S_WIN: begin
          sum          <= sum - jam_pkg::SUM_W'(window[slot]) + jam_pkg::SUM_W'(angle);
          window[slot] <= angle;
          slot         <= (slot == jam_pkg::SLOT_W'(jam_pkg::WINDOW - 1)) ? '0 : slot + 1'b1;
          if (held < jam_pkg::HELD_W'(jam_pkg::WINDOW)) begin
            held <= held + 1'b1;
          end
        end
        jam_pkg::S_ADIV: begin
          if (div_rsp.done) begin
            avg_off <= avg_s + jam_pkg::AO_W'(cfg.offset);
          end
        end
        jam_pkg::S_MAG: begin
          ua   <= avg_off[jam_pkg::AO_W-1] ? $unsigned(-avg_off) : $unsigned(avg_off);
          ur   <= cfg.ratio[jam_pkg::Q16_W-1] ? $unsigned(-cfg.ratio) : $unsigned(cfg.ratio);
          sneg <= avg_off[jam_pkg::AO_W-1] ^ cfg.ratio[jam_pkg::Q16_W-1];
        end
        jam_pkg::S_PLO: plo <= ua[jam_pkg::Q16_W-1:0] * ur;
        jam_pkg::S_PHI: phi <= ua[jam_pkg::AO_W-1:jam_pkg::Q16_W] * ur;
        jam_pkg::S_RND: begin
          if (can_load) begin
            out_angle <= jam_pkg::sat48(full_prod[jam_pkg::FULL_W-1:16], sneg);
          end
        end
        default: ;
      endcase
    end
  end

  assign result.valid       = out_valid;
  assign result.joint_angle = out_angle;

`ifndef ASSERT_OFF
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= jam_pkg::HELD_W'(jam_pkg::WINDOW)) else $error("sample count beyond window");
  a_load_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == jam_pkg::S_RND)
    else $error("result loaded outside rounding step");
`endif

endmodule

`default_nettype wire
